// ===== design/kmeans_pixel_cluster_engine_macros.svh =====
// Assertion macros for the k-means pixel cluster engine.
// Used by kmeans_pixel_cluster_engine.sv; expects clk and rst_n in scope.
`ifndef KMEANS_PIXEL_CLUSTER_ENGINE_MACROS_SVH
`define KMEANS_PIXEL_CLUSTER_ENGINE_MACROS_SVH
`ifndef SYNTH
`define KPCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KPCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KPCE_ASSERT_IMP(lbl, ante, cons)
`define KPCE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/kpce_pkg.sv =====
// Shared constants for the k-means pixel cluster engine.
// No dependencies.
`default_nettype none
package kpce_pkg;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF   = 25;
  localparam int NORM_BITS = 16;
  localparam int DISP_BITS = 8;
  localparam int SUM_BITS  = 40;
  localparam int DIST_BITS = 43;
  localparam int WGT_BITS  = 10;
  localparam int NCL_BITS  = 5;
  localparam int CFG_BITS  = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_WEIGHT = 2'd3;
  localparam logic [NCL_BITS-1:0]  RST_NUM_CLUSTERS = 5'd8;
  localparam logic [NORM_BITS-1:0] RST_INV          = 16'd64;
  localparam logic [WGT_BITS-1:0]  RST_DEPTH_WEIGHT = 10'd200;
  localparam logic ACT_LOAD = 1'b0;
endpackage
`default_nettype wire

// ===== design/kpce_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module kpce_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [ADDR_BITS-1:0]         waddr,
  input  wire  [WIDTH-1:0]             wdata,
  input  wire  [ADDR_BITS-1:0]         raddr,
  output logic [WIDTH-1:0]             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/kmeans_pixel_cluster_engine.sv =====
// Top level of the k-means pixel cluster engine (Lloyd step per pixel).
// Depends on kpce_pkg, kpce_ram and kmeans_pixel_cluster_engine_macros.svh.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | action, index, x, y, disparity, last
//  out_    | output    | out_valid / out_ready| label, best_distance, pass_done
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// A load transaction multiplies, saturates and writes the center.
// An assign transaction visits each of the K clusters in use, in turn: each
// center costs a RAM read, the squares, the weighted term and the compare.
// A pass-ending pixel adds per center a read and a check, plus for a non-empty
// cluster the bit-serial 40-bit mean divider and a write. Reset is synchronous;
// valid bits make all stores read as zero at once, so no clearing pass runs.
// A waiting result does not block the next transaction until its own end.
`default_nettype none
`include "kmeans_pixel_cluster_engine_macros.svh"
module kmeans_pixel_cluster_engine #(
  parameter int MAX_CLUSTERS = kpce_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = kpce_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS   = kpce_pkg::COUNT_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_action,
  input  wire  [3:0]                           in_cluster_index,
  input  wire  [COORD_BITS-1:0]                in_x_coord,
  input  wire  [COORD_BITS-1:0]                in_y_coord,
  input  wire  [kpce_pkg::DISP_BITS-1:0]       in_disparity,
  input  wire                                  in_last_of_pass,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [3:0]                           out_label,
  output logic [kpce_pkg::SUM_BITS-1:0]        out_best_distance,
  output logic                                 out_pass_done,
  input  wire                                  cfg_we,
  input  wire  [kpce_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire  [kpce_pkg::CFG_BITS-1:0]        cfg_data
);
  localparam int NB  = kpce_pkg::NORM_BITS;
  localparam int SB  = kpce_pkg::SUM_BITS;
  localparam int DB  = kpce_pkg::DIST_BITS;
  localparam int WB  = kpce_pkg::WGT_BITS;
  localparam int AW  = $clog2(MAX_CLUSTERS + 1);   // counter width
  localparam int IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;  // RAM address
  localparam int PB  = COORD_BITS + NB;
  localparam int CW  = 3 * NB;
  localparam int SW  = 3 * SB + COUNT_BITS;
  localparam int DCW = $clog2(SB);
  localparam logic [NB-1:0] Q16_MAX = {NB{1'b1}};
  localparam logic [SB-1:0] SUM_MAX = {SB{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_WT   = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_ARD  = 4'd7;
  localparam logic [3:0] S_AWR  = 4'd8;
  localparam logic [3:0] S_URD  = 4'd9;
  localparam logic [3:0] S_UCHK = 4'd10;
  localparam logic [3:0] S_UDIV = 4'd11;
  localparam logic [3:0] S_UWR  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // Configuration registers
  logic [kpce_pkg::NCL_BITS-1:0] num_clusters_r;
  logic [NB-1:0] inv_width_r, inv_height_r;
  logic [WB-1:0] depth_weight_r;
  logic [AW-1:0] k_clusters;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= kpce_pkg::RST_NUM_CLUSTERS;
      inv_width_r    <= kpce_pkg::RST_INV;
      inv_height_r   <= kpce_pkg::RST_INV;
      depth_weight_r <= kpce_pkg::RST_DEPTH_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        kpce_pkg::REG_NUM_CLUSTERS: num_clusters_r <= cfg_data[kpce_pkg::NCL_BITS-1:0];
        kpce_pkg::REG_INV_WIDTH:    inv_width_r    <= cfg_data[NB-1:0];
        kpce_pkg::REG_INV_HEIGHT:   inv_height_r   <= cfg_data[NB-1:0];
        kpce_pkg::REG_DEPTH_WEIGHT: depth_weight_r <= cfg_data[WB-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the cluster count to one through MAX_CLUSTERS
  always_comb begin
    if (num_clusters_r == '0) begin
      k_clusters = AW'(1);
    end else if (32'(num_clusters_r) > MAX_CLUSTERS) begin
      k_clusters = AW'(MAX_CLUSTERS);
    end else begin
      k_clusters = AW'(num_clusters_r);
    end
  end

  // Sequencer and datapath registers
  logic [3:0]    state_r, state_nxt;
  logic          act_r, last_r;
  logic [3:0]    idx_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [kpce_pkg::DISP_BITS-1:0] disp_r;
  logic [PB-1:0] px_r, py_r;
  logic [NB-1:0] nx_r, ny_r, nd_r, nx_c, ny_c, nd_c;
  logic [AW-1:0] ctr_r, label_r;
  logic [2*NB-1:0] sqx_r, sqy_r, sqd_r;
  logic [2*NB:0]   sxy_r;
  logic [2*NB+WB-1:0] wdd_r;
  logic [DB-1:0] best_r, dist_c;
  logic [DCW-1:0] dcnt_r;
  logic [SB-1:0]  quo_r [3];
  logic [COUNT_BITS-1:0] rem_r [3];
  logic [COUNT_BITS-1:0] divisor_r;
  logic [MAX_CLUSTERS-1:0] cvld_r, svld_r;
  logic cvld_q_r, svld_q_r;
  logic out_valid_r, out_pass_done_r;
  logic [3:0] out_label_r;
  logic [SB-1:0] out_dist_r;

  // RAM ports
  logic          c_we, s_we;
  logic [IW-1:0] c_waddr, c_raddr, s_raddr;
  logic [CW-1:0] c_wdata, c_rdata, c_q;
  logic [SW-1:0] s_wdata, s_rdata, s_q;
  logic [NB-1:0] cx, cy, cd, dx, dy, dd;
  logic [SB-1:0] sx, sy, sd;
  logic [COUNT_BITS-1:0] scnt;
  logic [SB:0]   ax, ay, ad;
  logic [SB-1:0] ax_s, ay_s, ad_s;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [NB-1:0] qx, qy, qd;
  logic out_fire, done_go, next_last;

  assign in_ready = (state_r == S_IDLE);
  assign out_fire = out_valid_r && out_ready;
  assign done_go  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign next_last = ((ctr_r + AW'(1)) == k_clusters);

  kpce_ram #(.WIDTH(CW), .DEPTH(MAX_CLUSTERS)) u_center_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );
  kpce_ram #(.WIDTH(SW), .DEPTH(MAX_CLUSTERS)) u_sum_ram (
    .clk(clk), .we(s_we), .waddr(label_r[IW-1:0]), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // Normalized coordinates: saturate the reciprocal products to Q0.16
  assign nx_c = (|px_r[PB-1:NB]) ? Q16_MAX : px_r[NB-1:0];
  assign ny_c = (|py_r[PB-1:NB]) ? Q16_MAX : py_r[NB-1:0];
  assign nd_c = {disp_r, disp_r};

  // Entries never written read as zero
  assign c_q = cvld_q_r ? c_rdata : '0;
  assign s_q = svld_q_r ? s_rdata : '0;
  assign {cx, cy, cd} = c_q;
  assign {sx, sy, sd, scnt} = s_q;
  assign dx = (nx_r > cx) ? nx_r - cx : cx - nx_r;
  assign dy = (ny_r > cy) ? ny_r - cy : cy - ny_r;
  assign dd = (nd_r > cd) ? nd_r - cd : cd - nd_r;
  assign dist_c = DB'(sxy_r) + DB'(wdd_r);

  // Saturating accumulate into the winning cluster
  assign ax = {1'b0, sx} + (SB + 1)'(nx_r);
  assign ay = {1'b0, sy} + (SB + 1)'(ny_r);
  assign ad = {1'b0, sd} + (SB + 1)'(nd_r);
  assign ax_s = ax[SB] ? SUM_MAX : ax[SB-1:0];
  assign ay_s = ay[SB] ? SUM_MAX : ay[SB-1:0];
  assign ad_s = ad[SB] ? SUM_MAX : ad[SB-1:0];
  assign cnt_inc = (scnt == CNT_MAX) ? CNT_MAX : scnt + COUNT_BITS'(1);

  // Means, capped to 16 bits
  assign qx = (|quo_r[0][SB-1:NB]) ? Q16_MAX : quo_r[0][NB-1:0];
  assign qy = (|quo_r[1][SB-1:NB]) ? Q16_MAX : quo_r[1][NB-1:0];
  assign qd = (|quo_r[2][SB-1:NB]) ? Q16_MAX : quo_r[2][NB-1:0];

  assign s_we    = (state_r == S_AWR);
  assign s_wdata = {ax_s, ay_s, ad_s, cnt_inc};
  assign s_raddr = (state_r == S_ARD) ? label_r[IW-1:0] : ctr_r[IW-1:0];
  assign c_raddr = ctr_r[IW-1:0];

  always_comb begin
    c_we    = 1'b0;
    c_waddr = ctr_r[IW-1:0];
    c_wdata = {qx, qy, qd};
    if (state_r == S_NORM && act_r == kpce_pkg::ACT_LOAD &&
        32'(idx_r) < MAX_CLUSTERS) begin
      c_we    = 1'b1;
      c_waddr = IW'(idx_r);
      c_wdata = {nx_c, ny_c, nd_c};
    end else if (state_r == S_UWR) begin
      c_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_NORM;
      S_NORM: state_nxt = (act_r == kpce_pkg::ACT_LOAD) ? S_IDLE : S_RD;
      S_RD:   state_nxt = S_SQ;
      S_SQ:   state_nxt = S_WT;
      S_WT:   state_nxt = S_CMP;
      S_CMP:  state_nxt = next_last ? S_ARD : S_RD;
      S_ARD:  state_nxt = S_AWR;
      S_AWR:  state_nxt = last_r ? S_URD : S_DONE;
      S_URD:  state_nxt = S_UCHK;
      S_UCHK: begin
        if (scnt != '0) begin
          state_nxt = S_UDIV;
        end else begin
          state_nxt = next_last ? S_DONE : S_URD;
        end
      end
      S_UDIV: if (dcnt_r == DCW'(SB - 1)) state_nxt = S_UWR;
      S_UWR:  state_nxt = next_last ? S_DONE : S_URD;
      S_DONE: if (done_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cvld_r      <= '0;
      svld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (c_we) cvld_r[c_waddr] <= 1'b1;
      if (s_we) svld_r[label_r[IW-1:0]] <= 1'b1;
      if (done_go && last_r) svld_r <= '0;
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    logic [COUNT_BITS:0] trial;
    logic [SB-1:0] src [3];
    cvld_q_r <= cvld_r[c_raddr];
    svld_q_r <= svld_r[s_raddr];
    case (state_r)
      S_IDLE: begin
        act_r  <= in_action;
        idx_r  <= in_cluster_index;
        x_r    <= in_x_coord;
        y_r    <= in_y_coord;
        disp_r <= in_disparity;
        last_r <= in_last_of_pass;
      end
      S_MUL: begin
        px_r <= PB'(x_r * inv_width_r);
        py_r <= PB'(y_r * inv_height_r);
      end
      S_NORM: begin
        nx_r  <= nx_c;
        ny_r  <= ny_c;
        nd_r  <= nd_c;
        ctr_r <= '0;
      end
      S_SQ: begin
        sqx_r <= dx * dx;
        sqy_r <= dy * dy;
        sqd_r <= dd * dd;
      end
      S_WT: begin
        sxy_r <= (2 * NB + 1)'(sqx_r) + (2 * NB + 1)'(sqy_r);
        wdd_r <= depth_weight_r * sqd_r;
      end
      S_CMP: begin
        if (ctr_r == '0 || dist_c < best_r) begin
          best_r  <= dist_c;
          label_r <= ctr_r;
        end
        ctr_r <= ctr_r + AW'(1);
      end
      S_AWR: ctr_r <= '0;
      S_UCHK: begin
        src[0] = sx;
        src[1] = sy;
        src[2] = sd;
        for (int i = 0; i < 3; i++) begin
          quo_r[i] <= src[i];
          rem_r[i] <= '0;
        end
        divisor_r <= scnt;
        dcnt_r    <= '0;
        if (scnt == '0) ctr_r <= ctr_r + AW'(1);
      end
      S_UDIV: begin
        // One restoring step per lane: shift in the top bit, try a subtract
        for (int i = 0; i < 3; i++) begin
          trial = {rem_r[i], quo_r[i][SB-1]};
          if (trial >= {1'b0, divisor_r}) begin
            rem_r[i] <= COUNT_BITS'(trial - {1'b0, divisor_r});
            quo_r[i] <= {quo_r[i][SB-2:0], 1'b1};
          end else begin
            rem_r[i] <= trial[COUNT_BITS-1:0];
            quo_r[i] <= {quo_r[i][SB-2:0], 1'b0};
          end
        end
        dcnt_r <= dcnt_r + DCW'(1);
      end
      S_UWR: ctr_r <= ctr_r + AW'(1);
      S_DONE: begin
        if (done_go) begin
          out_label_r     <= 4'(label_r);
          out_dist_r      <= (|best_r[DB-1:SB]) ? SUM_MAX : best_r[SB-1:0];
          out_pass_done_r <= last_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_label         = out_label_r;
  assign out_best_distance = out_dist_r;
  assign out_pass_done     = out_pass_done_r;

  `KPCE_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == S_MUL)
  `KPCE_ASSERT_IMP(a_label_in_use, state_r == S_ARD, label_r < k_clusters)
  `KPCE_ASSERT_NXT(a_pass_clears, done_go && last_r, svld_r == '0)
  `KPCE_ASSERT_NXT(a_done_shows, done_go, out_valid_r)
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for kmeans_pixel_cluster_engine: random valid/ready traffic,
// an internal Lloyd k-means predictor, and field-by-field checking of each result.
// Depends on kpce_pkg and the engine RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCL = kpce_pkg::MAX_CLUSTERS_DEF;
  localparam logic [39:0] SAT40 = 40'hFF_FFFF_FFFF;
  localparam logic [24:0] CNT_SAT = '1;

  typedef struct packed {
    logic        action;
    logic [3:0]  cluster_index;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
    logic [7:0]  disparity;
    logic        last_of_pass;
  } pixel_t;

  typedef struct packed {
    logic [3:0]  label;
    logic [39:0] best_distance;
    logic        pass_done;
  } label_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_action = 1'b0, in_last_of_pass = 1'b0;
  logic [3:0] in_cluster_index = '0;
  logic [11:0] in_x_coord = '0, in_y_coord = '0;
  logic [7:0] in_disparity = '0;
  logic out_valid, out_ready = 1'b0;
  logic [3:0] out_label;
  logic [39:0] out_best_distance;
  logic out_pass_done;
  logic cfg_we = 1'b0;
  logic [kpce_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [kpce_pkg::CFG_BITS-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  kmeans_pixel_cluster_engine DUT (.*);

  // Predictor state: configuration and the cluster stores.
  logic [4:0]  num_clusters_q;
  logic [15:0] inv_width_q, inv_height_q;
  logic [9:0]  depth_weight_q;
  logic [15:0] cen_x [NCL], cen_y [NCL], cen_d [NCL];
  logic [39:0] acc_x [NCL], acc_y [NCL], acc_d [NCL];
  logic [24:0] members [NCL];

  pixel_t pending_pixels[$];
  label_t expected_labels[$];
  int errors = 0, matched = 0, pixels_sent = 0, passes_seen = 0;
  bit idle_off = 1'b0;
  int drv_gap = 0, mon_gap = 0;

  function automatic logic [15:0] norm_sat(logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] mean_q16(logic [39:0] s, logic [24:0] c);
    logic [39:0] q;
    q = s / 40'(c);
    return (q > 40'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [39:0] add_sat40(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? SAT40 : s[39:0];
  endfunction

  // Append one pixel transaction to the stimulus queue.
  task automatic queue_pixel(input pixel_t p);
    pending_pixels = {pending_pixels, p};
  endtask

  // Advance the clustering state by one accepted pixel transaction.
  task automatic cluster_predict(input pixel_t p);
    logic [15:0] nx, ny, nd;
    logic [63:0] dist_v, best, dx, dy, dd;
    int used, lbl;
    label_t r;
    nx = norm_sat(32'(p.x_coord) * 32'(inv_width_q));
    ny = norm_sat(32'(p.y_coord) * 32'(inv_height_q));
    nd = 16'(p.disparity * 16'd257);
    if (p.action == kpce_pkg::ACT_LOAD) begin
      cen_x[p.cluster_index] = nx;
      cen_y[p.cluster_index] = ny;
      cen_d[p.cluster_index] = nd;
      return;
    end
    used = (num_clusters_q == 0) ? 1 : (num_clusters_q > NCL ? NCL : num_clusters_q);
    best = '0;
    lbl = 0;
    for (int i = 0; i < used; i++) begin
      dx = (nx > cen_x[i]) ? nx - cen_x[i] : cen_x[i] - nx;
      dy = (ny > cen_y[i]) ? ny - cen_y[i] : cen_y[i] - ny;
      dd = (nd > cen_d[i]) ? nd - cen_d[i] : cen_d[i] - nd;
      dist_v = dx * dx + dy * dy + 64'(depth_weight_q) * dd * dd;
      if (i == 0 || dist_v < best) begin
        best = dist_v;
        lbl = i;
      end
    end
    acc_x[lbl] = add_sat40(acc_x[lbl], 40'(nx));
    acc_y[lbl] = add_sat40(acc_y[lbl], 40'(ny));
    acc_d[lbl] = add_sat40(acc_d[lbl], 40'(nd));
    if (members[lbl] != CNT_SAT) members[lbl] = members[lbl] + 25'd1;
    if (p.last_of_pass) begin
      for (int i = 0; i < used; i++) begin
        if (members[i] != 0) begin
          cen_x[i] = mean_q16(acc_x[i], members[i]);
          cen_y[i] = mean_q16(acc_y[i], members[i]);
          cen_d[i] = mean_q16(acc_d[i], members[i]);
        end
      end
      for (int i = 0; i < NCL; i++) begin
        acc_x[i] = '0; acc_y[i] = '0; acc_d[i] = '0; members[i] = '0;
      end
    end
    r.label = 4'(lbl);
    r.best_distance = (best > 64'(SAT40)) ? SAT40 : best[39:0];
    r.pass_done = p.last_of_pass;
    expected_labels = {expected_labels, r};
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, exp_v, matched);
  endtask

  // Driver: hold each transaction until accepted, idle in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cluster_predict(pending_pixels.pop_front());
        pixels_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 9) == 0) begin
          drv_gap <= $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_valid <= 1'b1;
          {in_action, in_cluster_index, in_x_coord, in_y_coord, in_disparity,
           in_last_of_pass} <= pending_pixels[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_labels.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_label), 0);
        end else begin
          label_t e;
          e = expected_labels.pop_front();
          if (out_label != e.label) report_mismatch("label", out_label, e.label);
          if (out_best_distance != e.best_distance)
            report_mismatch("best_distance", out_best_distance, e.best_distance);
          if (out_pass_done != e.pass_done)
            report_mismatch("pass_done", out_pass_done, e.pass_done);
          if (e.pass_done) passes_seen++;
          matched++;
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        mon_gap <= $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic pixel_t make_pixel(bit act, int idx, int x, int y, int d, bit last);
    pixel_t p;
    p.action = act; p.cluster_index = 4'(idx); p.x_coord = 12'(x);
    p.y_coord = 12'(y); p.disparity = 8'(d); p.last_of_pass = last;
    return p;
  endfunction

  task automatic write_reg(input logic [kpce_pkg::CFG_IDX_BITS-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= kpce_pkg::CFG_BITS'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kpce_pkg::REG_NUM_CLUSTERS: num_clusters_q = 5'(val);
      kpce_pkg::REG_INV_WIDTH:    inv_width_q = 16'(val);
      kpce_pkg::REG_INV_HEIGHT:   inv_height_q = 16'(val);
      kpce_pkg::REG_DEPTH_WEIGHT: depth_weight_q = 10'(val);
      default: ;
    endcase
  endtask

  // Wait for the block to drain; loads give no result, so allow their latency too.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || expected_labels.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // One pass: seed k centers, then stream mostly-clustered pixels, end with last.
  task automatic queue_pass(input int k, input int npix);
    int cx, cy;
    for (int i = 0; i < k; i++)
      queue_pixel(make_pixel(kpce_pkg::ACT_LOAD, i, $urandom_range(0, 4095),
        $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 1)));
    for (int n = 0; n < npix; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_pixel(make_pixel(1'b1, $urandom, $urandom, $urandom, $urandom, 1'b0));
      end else begin
        cx = $urandom_range(0, 3) * 1000;
        cy = $urandom_range(0, 3) * 1000;
        queue_pixel(make_pixel(1'b1, $urandom, cx + $urandom_range(0, 95),
          cy + $urandom_range(0, 95), $urandom_range(0, 255), 1'b0));
      end
    end
    queue_pixel(make_pixel(1'b1, $urandom, $urandom, $urandom, $urandom, 1'b1));
  endtask

  initial begin
    int total;
    num_clusters_q = kpce_pkg::RST_NUM_CLUSTERS;
    inv_width_q = kpce_pkg::RST_INV;
    inv_height_q = kpce_pkg::RST_INV;
    depth_weight_q = kpce_pkg::RST_DEPTH_WEIGHT;
    for (int i = 0; i < NCL; i++) begin
      cen_x[i] = '0; cen_y[i] = '0; cen_d[i] = '0;
      acc_x[i] = '0; acc_y[i] = '0; acc_d[i] = '0; members[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset config, all-zero centers (ties to index 0), extremes,
    // load ignoring last, loads beyond num_clusters, empty-cluster update.
    queue_pixel(make_pixel(1'b1, 0, 0, 0, 0, 1'b0));
    queue_pixel(make_pixel(1'b1, 15, 4095, 4095, 255, 1'b0));
    queue_pixel(make_pixel(kpce_pkg::ACT_LOAD, 15, 4095, 0, 255, 1'b1));
    queue_pixel(make_pixel(kpce_pkg::ACT_LOAD, 1, 100, 100, 10, 1'b0));
    queue_pixel(make_pixel(kpce_pkg::ACT_LOAD, 2, 100, 100, 10, 1'b0));
    queue_pixel(make_pixel(1'b1, 3, 100, 100, 10, 1'b0));
    queue_pixel(make_pixel(1'b1, 0, 4095, 4095, 255, 1'b1));
    queue_pixel(make_pixel(1'b1, 0, 1, 1, 1, 1'b1));
    wait_idle();
    // Extremes: max weight, saturating reciprocals, 16 clusters.
    write_reg(kpce_pkg::REG_NUM_CLUSTERS, 16);
    write_reg(kpce_pkg::REG_INV_WIDTH, 65535);
    write_reg(kpce_pkg::REG_INV_HEIGHT, 65535);
    write_reg(kpce_pkg::REG_DEPTH_WEIGHT, 1023);
    for (int i = 0; i < 16; i++)
      queue_pixel(make_pixel(kpce_pkg::ACT_LOAD, i, i, 15 - i, i * 17, 1'b0));
    queue_pixel(make_pixel(1'b1, 0, 4095, 0, 0, 1'b0));
    queue_pixel(make_pixel(1'b1, 0, 0, 4095, 255, 1'b1));
    wait_idle();
    write_reg(kpce_pkg::REG_NUM_CLUSTERS, 0);
    write_reg(kpce_pkg::REG_INV_WIDTH, 1);
    write_reg(kpce_pkg::REG_INV_HEIGHT, 1);
    write_reg(kpce_pkg::REG_DEPTH_WEIGHT, 0);
    queue_pixel(make_pixel(1'b1, 0, 4095, 4095, 255, 1'b1));
    wait_idle();

    // Random phases across several settings.
    total = 0;
    for (int ph = 0; total < 1400; ph++) begin
      int k, npix;
      k = (ph % 4 == 0) ? 16 : $urandom_range(1, 8);
      write_reg(kpce_pkg::REG_NUM_CLUSTERS, (ph % 7 == 3) ? 31 : k);
      write_reg(kpce_pkg::REG_INV_WIDTH, (ph % 5 == 0) ? 65535 : $urandom_range(1, 64));
      write_reg(kpce_pkg::REG_INV_HEIGHT, (ph % 5 == 1) ? 65535 : $urandom_range(1, 64));
      write_reg(kpce_pkg::REG_DEPTH_WEIGHT,
                (ph % 3 == 0) ? 1023 : $urandom_range(0, 1023));
      if (total > 1150) idle_off = 1'b1;
      for (int p = 0; p < 3; p++) begin
        npix = $urandom_range(10, 50);
        queue_pass((p == 0) ? k : $urandom_range(0, 2), npix);
        total += npix + 2;
      end
      wait_idle();
    end

    $display("covered %0d pixel transactions, %0d results, %0d pass updates",
             pixels_sent, matched, passes_seen);
    if (errors == 0 && expected_labels.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/kpce_pkg.sv
design/kpce_ram.sv
design/kmeans_pixel_cluster_engine.sv
tb/testbench.sv
